// ===== sv/slcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// slcfc_pkg
// shared types, constants and the byte-wide crc update for the frame checker
// ----------------------------------------------------------------------------
package slcfc_pkg;

    localparam int unsigned MIN_FRAME_BYTES = 10;

    localparam logic [7:0]  SYNC_FIRST   = 8'h55;
    localparam logic [7:0]  SYNC_SECOND  = 8'hAA;
    localparam logic [32:0] DATA_OFFSET  = 33'd8;
    localparam logic [32:0] COUNT_MAX    = {33{1'b1}};
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_SEEN = 2'd1,
        PH_SYNC = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OVERRUN  = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
    } item_t;

    typedef struct packed {
        status_t     check_status;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic [31:0] frame_length_field;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== sv/slcfc_in_reg.sv =====
// ----------------------------------------------------------------------------
// slcfc_in_reg
// input register stage, takes a word whenever it is empty or moving on
// ----------------------------------------------------------------------------
module slcfc_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  slcfc_pkg::item_t    in_item,
    input  logic                advance,
    output logic                item_valid,
    output slcfc_pkg::item_t    item
);
    import slcfc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/slcfc_frame_track.sv =====
// ----------------------------------------------------------------------------
// slcfc_frame_track
// sync search, header length capture, crc update and end of buffer verdict
// ----------------------------------------------------------------------------
module slcfc_frame_track (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  slcfc_pkg::item_t    item,
    output slcfc_pkg::result_t result
);
    import slcfc_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [32:0] count_reg,  count_next;
    logic [31:0] length_reg, length_next;
    logic [15:0] crc_reg,    crc_next;
    logic [15:0] last2_reg,  last2_next;
    logic [32:0] need;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        crc_next    = crc_reg;
        last2_next  = last2_reg;
        unique case (phase_reg)
            PH_SYNC:
            begin
                if (count_reg[32:3] == 30'd0 && count_reg[2])
                begin
                    length_next = length_reg |
                        ({24'd0, item.rx_byte} << {count_reg[1:0], 3'b000});
                end
                if (count_reg >= DATA_OFFSET &&
                    count_reg < DATA_OFFSET + {1'b0, length_reg})
                begin
                    crc_next = crc16_byte(crc_reg, item.rx_byte);
                end
                last2_next = {item.rx_byte, last2_reg[15:8]};
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 33'd1;
                end
            end
            PH_SEEN:
            begin
                if (item.rx_byte == SYNC_SECOND)
                begin
                    phase_next = PH_SYNC;
                    count_next = 33'd2;
                    last2_next = {SYNC_SECOND, SYNC_FIRST};
                end
                else if (item.rx_byte != SYNC_FIRST)
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = (item.rx_byte == SYNC_FIRST) ? PH_SEEN : PH_HUNT;
            end
        endcase
    end

    // verdict on the updated state
    assign need = DATA_OFFSET + {1'b0, length_next};

    always_comb
    begin
        result = '0;
        if (phase_next != PH_SYNC || count_next < 33'(MIN_FRAME_BYTES))
        begin
            result.check_status = ST_SHORT;
        end
        else
        begin
            result.received_crc       = last2_next;
            result.frame_length_field = length_next;
            if (need > count_next)
            begin
                result.check_status = ST_OVERRUN;
            end
            else
            begin
                result.computed_crc = crc_next;
                result.check_status = (crc_next == last2_next) ? ST_OK : ST_MISMATCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            length_reg <= '0;
            crc_reg    <= CRC_INIT;
            last2_reg  <= '0;
        end
        else if (fire)
        begin
            if (item.end_of_buffer)
            begin
                phase_reg  <= PH_HUNT;
                count_reg  <= '0;
                length_reg <= '0;
                crc_reg    <= CRC_INIT;
                last2_reg  <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                length_reg <= length_next;
                crc_reg    <= crc_next;
                last2_reg  <= last2_next;
            end
        end
    end

endmodule

// ===== sv/slcfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// slcfc_out_reg
// result register, holds a verdict until the downstream side takes it
// ----------------------------------------------------------------------------
module slcfc_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                load_valid,
    input  slcfc_pkg::result_t  load_result,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                advance,
    output slcfc_pkg::result_t  out_result
);
    import slcfc_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign advance    = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load && load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load && load_valid)
        begin
            result_reg <= load_result;
        end
    end

endmodule

// ===== sv/sync_length_crc16_frame_checker.sv =====
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_checker
// Takes one buffer byte per clock while not stalled and, on the byte flagged
// as last, gives a verdict word. A byte passes an input register and then
// the sync, length and crc logic, and the verdict is then registered in the
// result register; one byte per cycle is sustained, set by the byte-wide crc
// update between the input and result registers. The result register holds
// a verdict until taken; while it is full and not taken, input stalls once
// the input register is full. No startup pass after reset.
// ----------------------------------------------------------------------------
module sync_length_crc16_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    // check_status [1:0], computed_crc [17:2], received_crc [33:18],
    // frame_length_field [65:34], zero [71:66]
    output logic [71:0] m_tdata
);
    import slcfc_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t out_result;

    assign in_item.rx_byte       = s_tdata;
    assign in_item.end_of_buffer = s_tlast;

    slcfc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    slcfc_frame_track u_frame_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (item_valid && advance),
        .item   (item),
        .result (result)
    );

    slcfc_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (item_valid),
        .load_valid  (item.end_of_buffer),
        .load_result (result),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .advance     (advance),
        .out_result  (out_result)
    );

    assign m_tdata = {6'd0,
                      out_result.frame_length_field,
                      out_result.received_crc,
                      out_result.computed_crc,
                      out_result.check_status};

endmodule

// ===== sim/sync_length_crc16_frame_checker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_checker_tb
// Streams framed byte buffers into the checker: mostly well-formed frames with
// random content, plus corrupted, overrun, overlapping, short and noise
// buffers. Both sides stall at random. A scoreboard predicts each buffer's
// verdict word and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
import slcfc_pkg::*;

class frame_verdict_board;
    phase_t      phase;
    logic [32:0] count;
    logic [31:0] len;
    logic [15:0] crc;
    logic [15:0] tail;
    result_t     pending[$];
    int          errors;

    function new();
        errors = 0;
        restart();
    endfunction

    static function logic [15:0] crc_after(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function void restart();
        phase = PH_HUNT;
        count = '0;
        len   = '0;
        crc   = CRC_INIT;
        tail  = '0;
    endfunction

    function void take(input logic [7:0] b);
        if (count >= 4 && count <= 7)
        begin
            len = len | ({24'h0, b} << (8 * count[1:0]));
        end
        if (count >= DATA_OFFSET && (count - DATA_OFFSET) < {1'b0, len})
        begin
            crc = crc_after(crc, b);
        end
        tail = {b, tail[15:8]};
        if (count != COUNT_MAX)
        begin
            count = count + 1'b1;
        end
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
        result_t     want;
        logic [32:0] need;
        case (phase)
            PH_SYNC:
            begin
                take(b);
            end
            PH_SEEN:
            begin
                if (b == SYNC_SECOND)
                begin
                    phase = PH_SYNC;
                    take(SYNC_FIRST);
                    take(b);
                end
                else if (b != SYNC_FIRST)
                begin
                    phase = PH_HUNT;
                end
            end
            default:
            begin
                phase = (b == SYNC_FIRST) ? PH_SEEN : PH_HUNT;
            end
        endcase
        if (last)
        begin
            want = '0;
            if (phase != PH_SYNC || count < MIN_FRAME_BYTES)
            begin
                want.check_status = ST_SHORT;
            end
            else
            begin
                need = DATA_OFFSET + {1'b0, len};
                if (need > count)
                begin
                    want.check_status = ST_OVERRUN;
                end
                else
                begin
                    want.check_status = (crc == tail) ? ST_OK : ST_MISMATCH;
                    want.computed_crc = crc;
                end
                want.received_crc       = tail;
                want.frame_length_field = len;
            end
            pending.push_back(want);
            restart();
        end
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_word(input logic [71:0] word);
        result_t want;
        if (pending.size() == 0)
        begin
            $error("verdict word %h with none expected", word);
            errors++;
        end
        else
        begin
            want = pending.pop_front();
            compare_field("check_status", 32'(want.check_status), 32'(word[1:0]));
            compare_field("computed_crc", 32'(want.computed_crc), 32'(word[17:2]));
            compare_field("received_crc", 32'(want.received_crc), 32'(word[33:18]));
            compare_field("frame_length_field", want.frame_length_field, word[65:34]);
        end
    endfunction
endclass

module sync_length_crc16_frame_checker_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_COUNT  = 1450;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    frame_verdict_board board;
    item_t              buffer_q[$];
    int                 bytes_sent  = 0;
    int                 cycle_count = 0;

    sync_length_crc16_frame_checker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // handshakes sampled on the falling edge ahead of the edge that completes them
    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (m_tvalid && m_tready)
            begin
                board.check_word(m_tdata);
            end
            if (s_tvalid && s_tready)
            begin
                board.note_byte(s_tdata, s_tlast);
            end
        end
    end

    function void push_byte(input logic [7:0] b);
        item_t it;
        it.rx_byte       = b;
        it.end_of_buffer = 1'b0;
        buffer_q.push_back(it);
    endfunction

    function void close_buffer();
        buffer_q[buffer_q.size() - 1].end_of_buffer = 1'b1;
    endfunction

    function void build_random_buffer();
        int unsigned kind;
        int unsigned n;
        logic [31:0] len;
        logic [15:0] crc;
        logic [7:0]  b;
        kind = $urandom_range(0, 19);
        if (kind < 2)
        begin
            repeat ($urandom_range(1, 14)) push_byte(8'($urandom));
        end
        else if (kind < 4)
        begin
            push_byte(SYNC_FIRST);
            push_byte(SYNC_SECOND);
            repeat ($urandom_range(0, 7)) push_byte(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                b = 8'($urandom);
                push_byte((b == SYNC_FIRST) ? 8'h00 : b);
            end
            if (kind == 4)
            begin
                push_byte(SYNC_FIRST);
            end
            push_byte(SYNC_FIRST);
            push_byte(SYNC_SECOND);
            push_byte(8'($urandom));
            push_byte(8'($urandom));
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20);
            len = n;
            if (kind == 16)
            begin
                len = n + $urandom_range(3, 40);
            end
            else if (kind == 17)
            begin
                len = $urandom;
            end
            else if (kind == 18)
            begin
                // data region runs into the crc bytes
                len = n + $urandom_range(1, 2);
            end
            for (int i = 0; i < 4; i++)
            begin
                push_byte(len[8 * i +: 8]);
            end
            crc = CRC_INIT;
            repeat (n)
            begin
                b = 8'($urandom);
                push_byte(b);
                crc = crc16_byte(crc, b);
            end
            if (kind == 14 || kind == 15)
            begin
                crc = crc ^ (16'h1 << $urandom_range(0, 15));
            end
            push_byte(crc[7:0]);
            push_byte(crc[15:8]);
            if (kind == 19)
            begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            end
        end
        close_buffer();
    endfunction

    task automatic send_buffer();
        bit calm;
        bit got;
        int gap;
        calm = ($urandom_range(0, 2) == 0);
        foreach (buffer_q[i])
        begin
            gap = calm ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= buffer_q[i].rx_byte;
            s_tlast  <= buffer_q[i].end_of_buffer;
            do
            begin
                @(negedge clk);
                got = s_tready;
                @(posedge clk);
            end
            while (!got);
            bytes_sent++;
        end
        buffer_q.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // result side
    initial
    begin
        int stall    = 0;
        int run_left = 0;
        bit calm     = 1'b0;
        bit got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (run_left == 0)
            begin
                calm     = ($urandom_range(0, 2) == 0);
                run_left = $urandom_range(4, 12);
            end
            run_left--;
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = m_tvalid;
                @(posedge clk);
            end
            while (!got);
        end
    end

    initial
    begin
        int buffers = 0;
        board    = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone byte, no sync ever seen
        push_byte(8'hFF);
        close_buffer();
        send_buffer();
        // repeated sync byte, zero length, crc left at its initial value
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        repeat (6) push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hFF);
        close_buffer();
        send_buffer();
        // header with all-ones length, one byte short of the minimum
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(8'h00);
        push_byte(8'h00);
        repeat (4) push_byte(8'hFF);
        push_byte(8'h00);
        close_buffer();
        send_buffer();

        while (bytes_sent < ITEM_COUNT)
        begin
            build_random_buffer();
            send_buffer();
            buffers++;
            if (buffers % 20 == 0)
            begin
                drain();
            end
        end
        drain();
        repeat (20) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/slcfc_pkg.sv
sv/slcfc_in_reg.sv
sv/slcfc_frame_track.sv
sv/slcfc_out_reg.sv
sv/sync_length_crc16_frame_checker.sv
sim/sync_length_crc16_frame_checker_tb.sv
